FILE: src/comit_pkg.sv
// shared constants and types for the center of mass and inertia tensor block
// no dependencies
package comit_pkg;

  // atom store size and derived widths
  localparam int unsigned MaxAtoms  = 1024;
  localparam int unsigned AddrW     = (MaxAtoms > 1) ? $clog2(MaxAtoms) : 1;
  localparam int unsigned CntW      = $clog2(MaxAtoms + 1);
  localparam int unsigned MassW     = 16;
  localparam int unsigned CoordW    = 20;
  localparam int unsigned MassSumW  = MassW + CntW;
  localparam int unsigned MProdW    = MassW + 1 + CoordW;
  localparam int unsigned CoordSumW = MProdW + CntW;
  localparam int unsigned WordW     = MassW + 3 * CoordW;

  // tensor datapath widths
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned SqW    = 2 * DiffW;
  localparam int unsigned OpaW   = SqW + 2;
  localparam int unsigned OpbW   = DiffW + 1;
  localparam int unsigned ProdW  = OpaW + OpbW;
  localparam int unsigned AccW   = 64;
  localparam int unsigned NumAcc = 6;

  localparam logic [MassW-1:0] UnitMass = 16'd64;

  // multiplier step codes of the tensor unit
  typedef enum logic [3:0] {
    STEP_XX  = 4'd0,
    STEP_YY  = 4'd1,
    STEP_ZZ  = 4'd2,
    STEP_XY  = 4'd3,
    STEP_XZ  = 4'd4,
    STEP_YZ  = 4'd5,
    STEP_MXX = 4'd6,
    STEP_MYY = 4'd7,
    STEP_MZZ = 4'd8,
    STEP_MXY = 4'd9,
    STEP_MXZ = 4'd10,
    STEP_MYZ = 4'd11
  } step_e;

  // sequencer states
  typedef enum logic [6:0] {
    ST_LOAD    = 7'b0000001,
    ST_DIVGO   = 7'b0000010,
    ST_DIVWAIT = 7'b0000100,
    ST_RD      = 7'b0001000,
    ST_SUB     = 7'b0010000,
    ST_MAC     = 7'b0100000,
    ST_OUT     = 7'b1000000
  } state_e;

  typedef struct packed {
    logic start;
    logic clear;
  } mac_ctrl_t;

  typedef struct packed {
    logic done;
    logic sat_any;
  } mac_stat_t;

endpackage

FILE: src/comit_in_if.sv
// atom input channel: valid/ready handshake with one atom per word
// depends on nothing
interface comit_in_if;
  logic                valid;
  logic                ready;
  logic signed [19:0]  pos_x;
  logic signed [19:0]  pos_y;
  logic signed [19:0]  pos_z;
  logic        [15:0]  atom_mass;
  logic                last_atom;

  modport source (output valid, pos_x, pos_y, pos_z, atom_mass, last_atom, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, atom_mass, last_atom, output ready);
endinterface

FILE: src/comit_out_if.sv
// result channel: center of mass, inertia tensor and flags in one word
// depends on nothing
interface comit_out_if;
  logic                valid;
  logic                ready;
  logic signed [19:0]  center_x;
  logic signed [19:0]  center_y;
  logic signed [19:0]  center_z;
  logic signed [63:0]  inertia_xx;
  logic signed [63:0]  inertia_yy;
  logic signed [63:0]  inertia_zz;
  logic signed [63:0]  inertia_xy;
  logic signed [63:0]  inertia_xz;
  logic signed [63:0]  inertia_yz;
  logic                zero_mass;
  logic                overflowed;

  modport source (output valid, center_x, center_y, center_z, inertia_xx, inertia_yy,
                  inertia_zz, inertia_xy, inertia_xz, inertia_yz, zero_mass, overflowed,
                  input ready);
  modport sink   (input valid, center_x, center_y, center_z, inertia_xx, inertia_yy,
                  inertia_zz, inertia_xy, inertia_xz, inertia_yz, zero_mass, overflowed,
                  output ready);
endinterface

FILE: src/comit_div.sv
// radix-2 restoring divider: rounded signed quotient of a weighted sum by total mass
// depends on comit_pkg
module comit_div (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic signed [comit_pkg::CoordSumW-1:0] num_i,
  input  logic        [comit_pkg::MassSumW-1:0]  den_i,
  output logic                                   done_o,
  output logic signed [comit_pkg::CoordW-1:0]    quot_o
);

  localparam int unsigned NW   = comit_pkg::CoordSumW + 2;
  localparam int unsigned DW   = comit_pkg::MassSumW + 1;
  localparam int unsigned RemW = comit_pkg::MassSumW + 2;
  localparam int unsigned CW   = $clog2(NW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [NW-1:0]   nq_q, nq_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [DW-1:0]   d_q, d_d;
  logic            neg_q, neg_d;

  logic [comit_pkg::CoordSumW-1:0] mag;
  logic [RemW-1:0]                 shifted;
  logic                            ge;
  logic [comit_pkg::CoordW:0]      qmag;
  logic [comit_pkg::CoordW:0]      qsgn;

  // magnitude of the numerator, then n = 2|num| + den, d = 2 den
  assign mag     = num_i[comit_pkg::CoordSumW-1] ? comit_pkg::CoordSumW'(-num_i)
                                                  : comit_pkg::CoordSumW'(num_i);
  assign shifted = {rem_q[RemW-2:0], nq_q[NW-1]};
  assign ge      = (shifted >= {1'b0, d_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    nq_d   = nq_q;
    rem_d  = rem_q;
    d_d    = d_q;
    neg_d  = neg_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      nq_d   = {1'b0, mag, 1'b0} + {{(NW - comit_pkg::MassSumW){1'b0}}, den_i};
      rem_d  = '0;
      d_d    = {den_i, 1'b0};
      neg_d  = num_i[comit_pkg::CoordSumW-1];
    end else if (busy_q) begin
      // one quotient bit per cycle
      rem_d = ge ? RemW'(shifted - {1'b0, d_q}) : shifted;
      nq_d  = {nq_q[NW-2:0], ge};
      cnt_d = CW'(cnt_q + 1'b1);
      if (cnt_q == CW'(NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nq_q  <= nq_d;
    rem_q <= rem_d;
    d_q   <= d_d;
    neg_q <= neg_d;
  end

  // quotient fits the coordinate range, apply the sign
  assign qmag   = nq_q[comit_pkg::CoordW:0];
  assign qsgn   = neg_q ? (comit_pkg::CoordW + 1)'(-qmag) : qmag;
  assign quot_o = qsgn[comit_pkg::CoordW-1:0];
  assign done_o = done_q;

endmodule

FILE: src/comit_mac.sv
// shared multiplier with six saturating accumulators for the inertia tensor
// depends on comit_pkg
module comit_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  comit_pkg::mac_ctrl_t                 ctrl_i,
  input  logic signed [comit_pkg::DiffW-1:0]   dx_i,
  input  logic signed [comit_pkg::DiffW-1:0]   dy_i,
  input  logic signed [comit_pkg::DiffW-1:0]   dz_i,
  input  logic        [comit_pkg::MassW-1:0]   mass_i,
  output comit_pkg::mac_stat_t                 stat_o,
  output logic signed [comit_pkg::AccW-1:0]    acc_o [comit_pkg::NumAcc]
);

  logic                                busy_q;
  comit_pkg::step_e                    step_q;
  logic signed [comit_pkg::DiffW-1:0]  dx_q, dy_q, dz_q;
  logic        [comit_pkg::MassW-1:0]  m_q;
  logic signed [comit_pkg::SqW-1:0]    sq_q [comit_pkg::NumAcc];
  logic signed [comit_pkg::AccW-1:0]   prod_q;
  logic                                pend_q;
  logic [2:0]                          tag_q;
  logic signed [comit_pkg::AccW-1:0]   acc_q [comit_pkg::NumAcc];
  logic [comit_pkg::NumAcc-1:0]        sat_q;

  logic signed [comit_pkg::OpaW-1:0]   opa;
  logic signed [comit_pkg::OpbW-1:0]   opb;
  logic signed [comit_pkg::ProdW-1:0]  prod;
  logic signed [comit_pkg::AccW-1:0]   term;
  logic signed [comit_pkg::AccW:0]     sum;
  logic signed [comit_pkg::OpbW-1:0]   mext;

  assign mext = $signed({{(comit_pkg::OpbW - comit_pkg::MassW){1'b0}}, m_q});

  // operand select for the shared multiplier
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (step_q)
      comit_pkg::STEP_XX:  begin opa = comit_pkg::OpaW'(dx_q); opb = comit_pkg::OpbW'(dx_q); end
      comit_pkg::STEP_YY:  begin opa = comit_pkg::OpaW'(dy_q); opb = comit_pkg::OpbW'(dy_q); end
      comit_pkg::STEP_ZZ:  begin opa = comit_pkg::OpaW'(dz_q); opb = comit_pkg::OpbW'(dz_q); end
      comit_pkg::STEP_XY:  begin opa = comit_pkg::OpaW'(dx_q); opb = comit_pkg::OpbW'(dy_q); end
      comit_pkg::STEP_XZ:  begin opa = comit_pkg::OpaW'(dx_q); opb = comit_pkg::OpbW'(dz_q); end
      comit_pkg::STEP_YZ:  begin opa = comit_pkg::OpaW'(dy_q); opb = comit_pkg::OpbW'(dz_q); end
      comit_pkg::STEP_MXX: begin
        opa = comit_pkg::OpaW'(sq_q[1]) + comit_pkg::OpaW'(sq_q[2]);
        opb = mext;
      end
      comit_pkg::STEP_MYY: begin
        opa = comit_pkg::OpaW'(sq_q[0]) + comit_pkg::OpaW'(sq_q[2]);
        opb = mext;
      end
      comit_pkg::STEP_MZZ: begin
        opa = comit_pkg::OpaW'(sq_q[0]) + comit_pkg::OpaW'(sq_q[1]);
        opb = mext;
      end
      comit_pkg::STEP_MXY: begin opa = comit_pkg::OpaW'(sq_q[3]); opb = mext; end
      comit_pkg::STEP_MXZ: begin opa = comit_pkg::OpaW'(sq_q[4]); opb = mext; end
      comit_pkg::STEP_MYZ: begin opa = comit_pkg::OpaW'(sq_q[5]); opb = mext; end
      default:             begin opa = '0; opb = '0; end
    endcase
  end

  assign prod = opa * opb;

  // step counter and pending product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= comit_pkg::STEP_XX;
      pend_q <= 1'b0;
      tag_q  <= '0;
    end else begin
      pend_q <= 1'b0;
      if (ctrl_i.start && !busy_q) begin
        busy_q <= 1'b1;
        step_q <= comit_pkg::STEP_XX;
      end else if (busy_q) begin
        if (step_q >= comit_pkg::STEP_MXX) begin
          pend_q <= 1'b1;
          tag_q  <= 3'(step_q - comit_pkg::STEP_MXX);
        end
        if (step_q == comit_pkg::STEP_MYZ) begin
          busy_q <= 1'b0;
        end else begin
          step_q <= comit_pkg::step_e'(step_q + 4'd1);
        end
      end
    end
  end

  // operand and product registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start && !busy_q) begin
      dx_q <= dx_i;
      dy_q <= dy_i;
      dz_q <= dz_i;
      m_q  <= mass_i;
    end
    if (busy_q && step_q < comit_pkg::STEP_MXX) begin
      sq_q[step_q[2:0]] <= prod[comit_pkg::SqW-1:0];
    end
    prod_q <= prod[comit_pkg::AccW-1:0];
  end

  // saturating accumulate, off-diagonal terms negated
  assign term = (tag_q >= 3'd3) ? -prod_q : prod_q;
  assign sum  = {acc_q[tag_q][comit_pkg::AccW-1], acc_q[tag_q]}
              + {term[comit_pkg::AccW-1], term};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= '0;
      for (int k = 0; k < comit_pkg::NumAcc; k++) acc_q[k] <= '0;
    end else if (ctrl_i.clear) begin
      sat_q <= '0;
      for (int k = 0; k < comit_pkg::NumAcc; k++) acc_q[k] <= '0;
    end else if (pend_q && !sat_q[tag_q]) begin
      if (sum[comit_pkg::AccW] != sum[comit_pkg::AccW-1]) begin
        sat_q[tag_q] <= 1'b1;
        acc_q[tag_q] <= term[comit_pkg::AccW-1] ? {1'b1, {(comit_pkg::AccW-1){1'b0}}}
                                                : {1'b0, {(comit_pkg::AccW-1){1'b1}}};
      end else begin
        acc_q[tag_q] <= sum[comit_pkg::AccW-1:0];
      end
    end
  end

  assign stat_o.done    = pend_q && (tag_q == 3'(comit_pkg::STEP_MYZ - comit_pkg::STEP_MXX));
  assign stat_o.sat_any = |sat_q;
  assign acc_o          = acc_q;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |-> !busy_q) else $error("tensor unit started while busy");
  a_sat_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_i.clear |=> (($past(sat_q) & ~sat_q) == '0)) else $error("saturation flag lost");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.done |-> !busy_q) else $error("done while steps remain");
`endif

endmodule

FILE: src/center_of_mass_inertia_tensor.sv
// center of mass and inertia tensor of a stored set of atoms
// depends on comit_pkg, comit_in_if, comit_out_if, comit_div, comit_mac
//
// atoms arrive on in_i, one word each, and are taken one per cycle while the
// block is loading. each atom is written to a 1024-entry store and added into
// the mass and weighted coordinate sums; atoms past the store size are dropped
// and flagged. the word marked last_atom starts the computation and in_i.ready
// stays low until the result word on out_o has been taken.
// after the last atom: three serial divisions, one per axis, each giving 50
// quotient bits at one per cycle, then for each stored atom: store read, offset,
// twelve passes through the one shared multiplier and the final accumulate.
// with zero total mass the sequencer goes from ST_DIVGO straight to ST_OUT.
// the result holds on out_o while out_o.ready is low; nothing else moves.
// reset clears the counts, sums and mass weighting (off); the store is not
// cleared, only written entries are read. cfg_we_i writes mass weighting and
// must only be used while the block is idle.
module center_of_mass_inertia_tensor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  comit_in_if.sink    in_i,
  comit_out_if.source out_o
);

  comit_pkg::state_e                         state_q, state_d;
  logic                                      weight_q;
  logic [comit_pkg::CntW-1:0]                cnt_q;
  logic [comit_pkg::CntW-1:0]                idx_q;
  logic                                      cap_q;
  logic                                      zero_q;
  logic [1:0]                                axis_q;
  logic        [comit_pkg::MassSumW-1:0]     msum_q;
  logic signed [comit_pkg::CoordSumW-1:0]    sx_q, sy_q, sz_q;
  logic signed [comit_pkg::CoordW-1:0]       cx_q, cy_q, cz_q;
  logic [comit_pkg::WordW-1:0]               mem [comit_pkg::MaxAtoms];
  logic [comit_pkg::WordW-1:0]               rdata_q;

  logic                                      in_acc, out_acc, store_ok;
  logic [comit_pkg::MassW-1:0]               m_eff;
  logic signed [comit_pkg::MProdW-1:0]       px, py, pz;
  logic signed [comit_pkg::CoordSumW-1:0]    div_num;
  logic                                      div_start, div_done;
  logic signed [comit_pkg::CoordW-1:0]       div_quot;
  comit_pkg::mac_ctrl_t                      mac_ctrl;
  comit_pkg::mac_stat_t                      mac_stat;
  logic signed [comit_pkg::DiffW-1:0]        dx, dy, dz;
  logic signed [comit_pkg::AccW-1:0]         acc [comit_pkg::NumAcc];

  assign in_i.ready = (state_q == comit_pkg::ST_LOAD);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;
  assign store_ok   = (cnt_q != comit_pkg::CntW'(comit_pkg::MaxAtoms));

  // weighted coordinates of the incoming atom
  assign m_eff = weight_q ? in_i.atom_mass : comit_pkg::UnitMass;
  assign px    = $signed({1'b0, m_eff}) * in_i.pos_x;
  assign py    = $signed({1'b0, m_eff}) * in_i.pos_y;
  assign pz    = $signed({1'b0, m_eff}) * in_i.pos_z;

  // mass weighting register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= 1'b0;
    end else if (cfg_we_i) begin
      weight_q <= cfg_wdata_i;
    end
  end

  // atom store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (in_acc && store_ok) begin
      mem[cnt_q[comit_pkg::AddrW-1:0]] <= {m_eff, in_i.pos_z, in_i.pos_y, in_i.pos_x};
    end
    rdata_q <= mem[idx_q[comit_pkg::AddrW-1:0]];
  end

  // divider operand select
  always_comb begin
    unique case (axis_q)
      2'd0:    div_num = sx_q;
      2'd1:    div_num = sy_q;
      default: div_num = sz_q;
    endcase
  end

  assign div_start = (state_q == comit_pkg::ST_DIVGO) && (msum_q != '0);

  comit_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (msum_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // offsets from the center for the atom just read
  assign dx = comit_pkg::DiffW'($signed(rdata_q[19:0]))  - comit_pkg::DiffW'(cx_q);
  assign dy = comit_pkg::DiffW'($signed(rdata_q[39:20])) - comit_pkg::DiffW'(cy_q);
  assign dz = comit_pkg::DiffW'($signed(rdata_q[59:40])) - comit_pkg::DiffW'(cz_q);

  assign mac_ctrl.start = (state_q == comit_pkg::ST_SUB);
  assign mac_ctrl.clear = in_acc && in_i.last_atom;

  comit_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .dx_i   (dx),
    .dy_i   (dy),
    .dz_i   (dz),
    .mass_i (rdata_q[75:60]),
    .stat_o (mac_stat),
    .acc_o  (acc)
  );

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      comit_pkg::ST_LOAD:    if (in_acc && in_i.last_atom) state_d = comit_pkg::ST_DIVGO;
      comit_pkg::ST_DIVGO:   state_d = (msum_q == '0) ? comit_pkg::ST_OUT
                                                      : comit_pkg::ST_DIVWAIT;
      comit_pkg::ST_DIVWAIT: begin
        if (div_done) state_d = (axis_q == 2'd2) ? comit_pkg::ST_RD : comit_pkg::ST_DIVGO;
      end
      comit_pkg::ST_RD:      state_d = comit_pkg::ST_SUB;
      comit_pkg::ST_SUB:     state_d = comit_pkg::ST_MAC;
      comit_pkg::ST_MAC: begin
        if (mac_stat.done) begin
          state_d = (comit_pkg::CntW'(idx_q + 1'b1) == cnt_q) ? comit_pkg::ST_OUT
                                                              : comit_pkg::ST_RD;
        end
      end
      comit_pkg::ST_OUT:     if (out_acc) state_d = comit_pkg::ST_LOAD;
      default:               state_d = comit_pkg::ST_LOAD;
    endcase
  end

  // control state, counts and sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= comit_pkg::ST_LOAD;
      cnt_q   <= '0;
      idx_q   <= '0;
      cap_q   <= 1'b0;
      zero_q  <= 1'b0;
      axis_q  <= '0;
      msum_q  <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      sz_q    <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        comit_pkg::ST_LOAD: begin
          if (in_acc) begin
            if (store_ok) begin
              cnt_q  <= comit_pkg::CntW'(cnt_q + 1'b1);
              msum_q <= msum_q + {{(comit_pkg::MassSumW - comit_pkg::MassW){1'b0}}, m_eff};
              sx_q   <= sx_q + comit_pkg::CoordSumW'(px);
              sy_q   <= sy_q + comit_pkg::CoordSumW'(py);
              sz_q   <= sz_q + comit_pkg::CoordSumW'(pz);
            end else begin
              cap_q <= 1'b1;
            end
            axis_q <= '0;
            idx_q  <= '0;
          end
        end
        comit_pkg::ST_DIVGO: zero_q <= (msum_q == '0);
        comit_pkg::ST_DIVWAIT: if (div_done) axis_q <= 2'(axis_q + 1'b1);
        comit_pkg::ST_MAC: if (mac_stat.done) idx_q <= comit_pkg::CntW'(idx_q + 1'b1);
        comit_pkg::ST_OUT: begin
          if (out_acc) begin
            cnt_q  <= '0;
            cap_q  <= 1'b0;
            zero_q <= 1'b0;
            msum_q <= '0;
            sx_q   <= '0;
            sy_q   <= '0;
            sz_q   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // center registers
  always_ff @(posedge clk_i) begin
    if (state_q == comit_pkg::ST_DIVGO && msum_q == '0) begin
      cx_q <= '0;
      cy_q <= '0;
      cz_q <= '0;
    end else if (state_q == comit_pkg::ST_DIVWAIT && div_done) begin
      unique case (axis_q)
        2'd0:    cx_q <= div_quot;
        2'd1:    cy_q <= div_quot;
        default: cz_q <= div_quot;
      endcase
    end
  end

  // result word
  assign out_o.valid      = (state_q == comit_pkg::ST_OUT);
  assign out_o.center_x   = cx_q;
  assign out_o.center_y   = cy_q;
  assign out_o.center_z   = cz_q;
  assign out_o.inertia_xx = acc[0];
  assign out_o.inertia_yy = acc[1];
  assign out_o.inertia_zz = acc[2];
  assign out_o.inertia_xy = acc[3];
  assign out_o.inertia_xz = acc[4];
  assign out_o.inertia_yz = acc[5];
  assign out_o.zero_mass  = zero_q;
  assign out_o.overflowed = cap_q || mac_stat.sat_any;

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= comit_pkg::CntW'(comit_pkg::MaxAtoms)) else $error("atom count past store size");
  a_zero_tensor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.zero_mass |-> out_o.inertia_xx == '0 && out_o.inertia_xy == '0
      && out_o.inertia_yz == '0) else $error("zero mass result with nonzero tensor");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == comit_pkg::ST_RD |-> idx_q < cnt_q) else $error("read past loaded atoms");
`endif

endmodule

FILE: bench/tb_center_of_mass_inertia_tensor.sv
`timescale 1ns / 1ps
// self-checking bench for the center of mass and inertia tensor block
// depends on comit_pkg, comit_in_if, comit_out_if and the block itself
module tb_center_of_mass_inertia_tensor;

  typedef struct packed {
    logic signed [19:0] cx, cy, cz;
    logic signed [63:0] ixx, iyy, izz, ixy, ixz, iyz;
    logic               zm, ovf;
  } tensor_word_t;

  typedef struct {
    logic signed [19:0] x, y, z;
    logic [15:0]        m;
    logic               last;
    logic               has_exp;
    tensor_word_t       exp_word;
  } atom_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;

  comit_in_if  atom_ch ();
  comit_out_if tensor_ch ();

  center_of_mass_inertia_tensor DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (atom_ch),
    .out_o      (tensor_ch)
  );

  // predictor state
  logic signed [19:0] pos_mem [comit_pkg::MaxAtoms][3];
  logic [15:0]        mass_mem [comit_pkg::MaxAtoms];
  int unsigned        n_atoms;
  bit                 dropped;
  longint             sum_m, sum_mx, sum_my, sum_mz;
  bit                 weighting;

  tensor_word_t expected_words[$];
  int errors = 0;
  int n_outstanding = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #400ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic longint center_div(longint num, longint den);
    longint unsigned mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag * 2 + den) / (den * 2);
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic void sat_accum(ref longint acc, ref bit sat, input longint term);
    if (sat) return;
    if (term > 0 && acc > 64'sh7FFFFFFFFFFFFFFF - term) begin
      acc = 64'sh7FFFFFFFFFFFFFFF;
      sat = 1;
    end else if (term < 0 && acc < $signed(64'h8000000000000000) - term) begin
      acc = $signed(64'h8000000000000000);
      sat = 1;
    end else begin
      acc += term;
    end
  endfunction

  // fold one atom into the predictor, returns 1 with a word when it closes a structure
  function automatic bit predict_atom(input logic signed [19:0] x, y, z,
                                      input logic [15:0] m_in, input logic last,
                                      output tensor_word_t w);
    longint c[3], t[6], m, dx, dy, dz;
    bit sat[6];
    logic [15:0] m_eff;
    w = '0;
    if (n_atoms < comit_pkg::MaxAtoms) begin
      m_eff = weighting ? m_in : comit_pkg::UnitMass;
      pos_mem[n_atoms][0] = x;
      pos_mem[n_atoms][1] = y;
      pos_mem[n_atoms][2] = z;
      mass_mem[n_atoms] = m_eff;
      sum_m  += m_eff;
      sum_mx += longint'(m_eff) * x;
      sum_my += longint'(m_eff) * y;
      sum_mz += longint'(m_eff) * z;
      n_atoms++;
    end else begin
      dropped = 1;
    end
    if (!last) return 0;
    foreach (t[k]) begin
      t[k] = 0;
      sat[k] = 0;
    end
    foreach (c[k]) c[k] = 0;
    w.zm = (sum_m == 0);
    w.ovf = dropped;
    if (!w.zm) begin
      c[0] = center_div(sum_mx, sum_m);
      c[1] = center_div(sum_my, sum_m);
      c[2] = center_div(sum_mz, sum_m);
      for (int i = 0; i < n_atoms; i++) begin
        m = mass_mem[i];
        dx = pos_mem[i][0] - c[0];
        dy = pos_mem[i][1] - c[1];
        dz = pos_mem[i][2] - c[2];
        sat_accum(t[0], sat[0], m * (dy * dy + dz * dz));
        sat_accum(t[1], sat[1], m * (dx * dx + dz * dz));
        sat_accum(t[2], sat[2], m * (dx * dx + dy * dy));
        sat_accum(t[3], sat[3], -(m * (dx * dy)));
        sat_accum(t[4], sat[4], -(m * (dx * dz)));
        sat_accum(t[5], sat[5], -(m * (dy * dz)));
      end
      foreach (sat[k]) if (sat[k]) w.ovf = 1;
    end
    w.cx = c[0][19:0];
    w.cy = c[1][19:0];
    w.cz = c[2][19:0];
    {w.ixx, w.iyy, w.izz, w.ixy, w.ixz, w.iyz} = {t[0], t[1], t[2], t[3], t[4], t[5]};
    n_atoms = 0;
    dropped = 0;
    sum_m = 0;
    sum_mx = 0;
    sum_my = 0;
    sum_mz = 0;
    return 1;
  endfunction

  // drop valid before the sender waits on anything else
  task automatic idle_sender();
    atom_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // send one atom, predicting on acceptance; valid stays up for a back to back word
  task automatic send_atom(input atom_row_t r);
    tensor_word_t w;
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      atom_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    atom_ch.valid     <= 1'b1;
    atom_ch.pos_x     <= r.x;
    atom_ch.pos_y     <= r.y;
    atom_ch.pos_z     <= r.z;
    atom_ch.atom_mass <= r.m;
    atom_ch.last_atom <= r.last;
    do @(posedge clk_i); while (!atom_ch.ready);
    if (predict_atom(r.x, r.y, r.z, r.m, r.last, w)) begin
      if (r.has_exp && w !== r.exp_word) begin
        errors++;
        if (errors <= 10) $display("table row expectation disagrees: %h vs %h", r.exp_word, w);
      end
      expected_words.push_back(w);
    end
  endtask

  task automatic write_weighting(input bit v);
    idle_sender();
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    weighting = v;
  endtask

  function automatic atom_row_t mk(input int x, y, z, input int m, input bit last);
    atom_row_t r;
    r.x = 20'(x);
    r.y = 20'(y);
    r.z = 20'(z);
    r.m = 16'(m);
    r.last = last;
    r.has_exp = 0;
    r.exp_word = '0;
    return r;
  endfunction

  function automatic logic signed [19:0] rnd_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 20'sh7FFFF : 20'sh80000;
      1: return 20'(int'($urandom_range(0, 2047)) - 1024);
      default: return 20'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rnd_mass();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // result side: random stall, compare with oldest expectation
  initial begin
    tensor_word_t got, want;
    int gap;
    tensor_ch.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        tensor_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      tensor_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!tensor_ch.valid);
      got = {tensor_ch.center_x, tensor_ch.center_y, tensor_ch.center_z,
             tensor_ch.inertia_xx, tensor_ch.inertia_yy, tensor_ch.inertia_zz,
             tensor_ch.inertia_xy, tensor_ch.inertia_xz, tensor_ch.inertia_yz,
             tensor_ch.zero_mass, tensor_ch.overflowed};
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", got);
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch center exp %h %h %h got %h %h %h", want.cx, want.cy, want.cz,
                     got.cx, got.cy, got.cz);
            $display("  tensor exp %h %h %h %h %h %h", want.ixx, want.iyy, want.izz,
                     want.ixy, want.ixz, want.iyz);
            $display("  tensor got %h %h %h %h %h %h", got.ixx, got.iyy, got.izz,
                     got.ixy, got.ixz, got.iyz);
            $display("  flags exp %b%b got %b%b", want.zm, want.ovf, got.zm, got.ovf);
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    atom_row_t table_rows[$];
    atom_row_t r;
    int sent, n;
    atom_ch.valid <= 1'b0;
    atom_ch.pos_x <= '0;
    atom_ch.pos_y <= '0;
    atom_ch.pos_z <= '0;
    atom_ch.atom_mass <= '0;
    atom_ch.last_atom <= 1'b0;
    weighting = 0;
    n_atoms = 0;
    dropped = 0;
    sum_m = 0;
    sum_mx = 0;
    sum_my = 0;
    sum_mz = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows, weighting off after reset
    r = mk(0, 0, 0, 0, 1);
    r.has_exp = 1;
    table_rows.push_back(r);
    r = mk(20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 0, 1);
    r.has_exp = 1;
    r.exp_word.cx = 20'sh7FFFF;
    r.exp_word.cy = 20'sh7FFFF;
    r.exp_word.cz = 20'sh7FFFF;
    table_rows.push_back(r);
    table_rows.push_back(mk(20'sh80000, 20'sh7FFFF, 20'sh80000, 5, 0));
    table_rows.push_back(mk(20'sh7FFFF, 20'sh80000, 20'sh7FFFF, 9, 1));
    table_rows.push_back(mk(1, -1, 0, 0, 0));
    table_rows.push_back(mk(2, -2, 1, 0, 1));
    foreach (table_rows[i]) send_atom(table_rows[i]);
    table_rows.delete();

    // weighting on: zero mass, extremes, rounding ties
    write_weighting(1);
    r = mk(20'sh7FFFF, 20'sh80000, 123, 0, 1);
    r.has_exp = 1;
    r.exp_word.zm = 1;
    table_rows.push_back(r);
    table_rows.push_back(mk(20'sh80000, 20'sh80000, 20'sh80000, 16'hFFFF, 0));
    table_rows.push_back(mk(20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 16'hFFFF, 0));
    table_rows.push_back(mk(20'sh80000, 20'sh7FFFF, 0, 16'hFFFF, 1));
    table_rows.push_back(mk(0, 0, 0, 1, 0));
    table_rows.push_back(mk(1, -1, 3, 1, 1));
    table_rows.push_back(mk(0, 0, 0, 3, 0));
    table_rows.push_back(mk(-1, 1, -5, 1, 1));
    foreach (table_rows[i]) send_atom(table_rows[i]);

    // full store, dropped atoms with a dropped last atom, saturation at extreme masses
    for (int i = 0; i < comit_pkg::MaxAtoms + 3; i++) begin
      r = mk((i & 1) ? 20'sh7FFFF : 20'sh80000, (i & 2) ? 20'sh7FFFF : 20'sh80000,
             (i & 4) ? 20'sh7FFFF : 20'sh80000, 16'hFFFF, i == comit_pkg::MaxAtoms + 2);
      send_atom(r);
    end

    // random structures, mostly small
    sent = 0;
    while (sent < 850) begin
      if ($urandom_range(0, 7) == 0) write_weighting(1'($urandom_range(0, 1)));
      if ($urandom_range(0, 9) == 0) begin
        idle_sender();
        while (expected_words.size() != 0) @(posedge clk_i);
      end
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        send_atom(mk(rnd_coord(), rnd_coord(), rnd_coord(),
                     ($urandom_range(0, 9) == 0) ? 0 : rnd_mass(), i == n - 1));
        sent++;
      end
    end

    idle_sender();
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/comit_pkg.sv
src/comit_in_if.sv
src/comit_out_if.sv
src/comit_div.sv
src/comit_mac.sv
src/center_of_mass_inertia_tensor.sv
bench/tb_center_of_mass_inertia_tensor.sv
